// ===== rtl/cffa_pkg.sv =====
// Package for the contiguous first-fit block allocator.
// Holds the beat payload types, register indexes, sequencer states and fixed constants.
// Depends on nothing; only the top level of the allocator imports it.
`default_nettype none

package cffa_pkg;

   localparam int REQ_BYTES_W   = 24;
   localparam int BSIZE_W       = 17;
   localparam int STORAGE_W     = 13;
   localparam int DIR_ID_W      = 12;
   localparam int START_W       = 12;
   localparam int ENTRY_W       = 12;
   localparam int ENTRY_CNT_W   = 13;
   localparam int TAKEN_W       = 13;
   localparam int USABLE_W      = 28;
   localparam int FREE_W        = 13;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 17;

   localparam logic [USABLE_W-1:0] USABLE_MAX = {USABLE_W{1'b1}};

   localparam logic [BSIZE_W-1:0]   BSIZE_RESET   = 17'd512;
   localparam logic [STORAGE_W-1:0] STORAGE_RESET = 13'd4096;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BSIZE          = 2'd0,
      CSR_STORAGE_BLOCKS = 2'd1,
      CSR_PARENT_DIR_ID  = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_CHECK,
      ST_SCAN,
      ST_MARK,
      ST_MUL,
      ST_DONE
   } alloc_state_type;

   typedef struct packed {
      logic [REQ_BYTES_W-1:0] request_bytes;
      logic                   is_file;
   } req_type;

   typedef struct packed {
      logic                   found;
      logic [START_W-1:0]     start_block;
      logic [ENTRY_W-1:0]     entry_number;
      logic [TAKEN_W-1:0]     blocks_taken;
      logic [USABLE_W-1:0]    usable_bytes;
      logic [FREE_W-1:0]      free_left;
      logic [DIR_ID_W-1:0]    parent_dir;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/cffa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the block free map; depends on no package.
`default_nettype none

module cffa_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/cffa_div.sv =====
// Restoring divider that retires one quotient bit per cycle.
// Computes the block count of a file request; depends on no package.
`default_nettype none

module cffa_div #(
   parameter int NUM_W = 25,
   parameter int DEN_W = 17
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] numer,
   input  wire logic [DEN_W-1:0] denom,
   output logic                  done,
   output logic      [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      fits    = (trial >= {1'b0, den_ff});
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         rem_in  = '0;
         den_in  = denom;
         quo_in  = numer;
      end else if (busy_ff) begin
         rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

`default_nettype wire

// ===== rtl/contiguous_first_fit_block_alloc.sv =====
// Top level of the contiguous first-fit block allocator: sequencer, free map and counters.
// Depends on cffa_pkg, cffa_ram and cffa_div.
`default_nettype none

// Each request beat asks for room for one directory entry. A folder takes one
// block; a file takes ceil((request_bytes + HEADER_BYTES) / the block size) blocks,
// with a block size of zero treated as one. The free map (one bit per block,
// held in a RAM) is searched from block 0 for the first run of that many free
// blocks within min(storage_blocks, MAP_BLOCKS). On a hit the run is marked used,
// the entry gets the next sequential number and the free count drops; otherwise
// found is 0 and nothing changes. Every request produces exactly one response beat.
// After reset the block first clears the free map, one block per cycle, so
// req_ready stays low until the whole map is cleared; CSR writes are taken
// throughout. A request then runs as: accept, the bit-serial divider for
// files (one quotient bit per cycle), a fit check (a zero-block file or a run
// longer than the scan goes straight to the response), the map scan at one
// map bit per cycle through the RAM read port (stopping at the first fitting
// run or at the end of the scan), on a hit the marking of the run through the
// RAM write port, block by block, and a multiply, and last the registered
// response. The next request is taken while an earlier response still waits
// for rsp_ready; the block only stalls when a new response is ready and the old
// one is unread. CSRs may only be written while no request is outstanding.

module contiguous_first_fit_block_alloc
   import cffa_pkg::*;
#(
   parameter int MAP_BLOCKS   = 4096,
   parameter int HEADER_BYTES = 96
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_type                req_payload,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_type                     rsp_payload,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Map addressing and counts that can reach the map size itself.
   localparam int ADDR_W  = $clog2(MAP_BLOCKS);
   localparam int CNT_W   = $clog2(MAP_BLOCKS + 1);
   // Largest divider numerator: bytes + header + block size - 1.
   localparam int NUM_W   = $clog2((1 << REQ_BYTES_W) + (1 << BSIZE_W) + HEADER_BYTES + 1);
   localparam int PROD_W  = CNT_W + BSIZE_W;
   localparam int WIDE_W  = (PROD_W > USABLE_W) ? PROD_W : USABLE_W;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_BLOCKS - 1);

   // Configuration registers.
   logic [BSIZE_W-1:0]   bsize_ff;
   logic [STORAGE_W-1:0] storage_ff;
   logic [DIR_ID_W-1:0]  dir_id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bsize_ff   <= BSIZE_RESET;
         storage_ff <= STORAGE_RESET;
         dir_id_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BSIZE:          bsize_ff   <= csr_wdata[BSIZE_W-1:0];
            CSR_STORAGE_BLOCKS: storage_ff <= csr_wdata[STORAGE_W-1:0];
            CSR_PARENT_DIR_ID:  dir_id_ff  <= csr_wdata[DIR_ID_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Effective block size and scan length.
   logic [BSIZE_W-1:0] bsize_eff;
   logic [CNT_W-1:0]   span;

   assign bsize_eff = (bsize_ff == '0) ? BSIZE_W'(1) : bsize_ff;
   assign span = (32'(storage_ff) < 32'(MAP_BLOCKS)) ? CNT_W'(storage_ff)
                                                    : CNT_W'(MAP_BLOCKS);

   // Sequencer and datapath registers.
   alloc_state_type     state_ff, state_in;
   logic [ADDR_W-1:0]   clr_ff, clr_in;
   logic [NUM_W-1:0]    needed_ff, needed_in;
   logic [CNT_W-1:0]    issue_ff, issue_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [CNT_W-1:0]    rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]    run_ff, run_in;
   logic [ADDR_W-1:0]   start_ff, start_in;
   logic [ADDR_W-1:0]   mark_addr_ff, mark_addr_in;
   logic [CNT_W-1:0]    mark_left_ff, mark_left_in;
   logic                hit_ff, hit_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [ENTRY_CNT_W-1:0] entries_ff, entries_in;
   logic [CNT_W-1:0]    alloc_ff, alloc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   // Free map RAM and divider hookup.
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic              ram_wdata;
   logic              ram_rdata;
   logic              div_start;
   logic              div_done;
   logic [NUM_W-1:0]  div_quot;
   logic [NUM_W-1:0]  div_numer;

   assign div_numer = NUM_W'(req_payload.request_bytes) + NUM_W'(HEADER_BYTES)
                    + NUM_W'(bsize_eff) - NUM_W'(1);

   cffa_ram #(
      .WIDTH (1),
      .DEPTH (MAP_BLOCKS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (issue_ff[ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   cffa_div #(
      .NUM_W (NUM_W),
      .DEN_W (BSIZE_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (bsize_eff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Response arithmetic, only meaningful in ST_DONE.
   logic [CNT_W-1:0]  run_next;
   logic [WIDE_W-1:0] prod_wide;
   logic [WIDE_W-1:0] usable_wide;
   logic [USABLE_W-1:0] usable;
   logic [CNT_W-1:0]  alloc_next;
   logic [CNT_W-1:0]  free_next;
   logic              rsp_load;

   always_comb begin
      prod_wide   = WIDE_W'(prod_ff);
      usable_wide = '0;
      if (prod_wide > WIDE_W'(HEADER_BYTES + 1)) begin
         usable_wide = prod_wide - WIDE_W'(HEADER_BYTES + 1);
      end
      // Saturate at the top of the response field.
      if (usable_wide > WIDE_W'(USABLE_MAX)) begin
         usable = USABLE_MAX;
      end else begin
         usable = USABLE_W'(usable_wide);
      end
      alloc_next = hit_ff ? (alloc_ff + CNT_W'(needed_ff)) : alloc_ff;
      // The storage size may have been lowered below what is already taken.
      free_next  = (span > alloc_next) ? (span - alloc_next) : '0;
   end

   assign run_next = run_ff + CNT_W'(1);
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      needed_in    = needed_ff;
      issue_in     = issue_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = issue_ff;
      run_in       = run_ff;
      start_in     = start_ff;
      mark_addr_in = mark_addr_ff;
      mark_left_in = mark_left_ff;
      hit_in       = hit_ff;
      prod_in      = prod_ff;
      entries_in   = entries_ff;
      alloc_in     = alloc_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      ram_we       = 1'b0;
      ram_waddr    = clr_ff;
      ram_wdata    = 1'b0;
      div_start    = 1'b0;
      req_ready    = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = 1'b0;
            clr_in    = clr_ff + ADDR_W'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_payload.is_file) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  needed_in = NUM_W'(1);
                  state_in  = ST_CHECK;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               needed_in = div_quot;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            issue_in = '0;
            run_in   = '0;
            hit_in   = 1'b0;
            // A zero-block file or a run longer than the scan cannot fit.
            if (needed_ff == '0 || 32'(needed_ff) > 32'(span)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Issue one map read per cycle until the end of the scan; the read data comes back registered.
            if (issue_ff < span) begin
               rd_vld_in = 1'b1;
               issue_in  = issue_ff + CNT_W'(1);
            end
            if (rd_vld_ff) begin
               if (!ram_rdata) begin
                  run_in = run_next;
                  if (32'(run_next) == 32'(needed_ff)) begin
                     hit_in       = 1'b1;
                     start_in     = ADDR_W'(rd_idx_ff - run_ff);
                     mark_addr_in = ADDR_W'(rd_idx_ff - run_ff);
                     mark_left_in = CNT_W'(needed_ff);
                     rd_vld_in    = 1'b0;
                     state_in     = ST_MARK;
                  end else if (rd_idx_ff + CNT_W'(1) == span) begin
                     rd_vld_in = 1'b0;
                     state_in  = ST_DONE;
                  end
               end else begin
                  run_in = '0;
                  if (rd_idx_ff + CNT_W'(1) == span) begin
                     rd_vld_in = 1'b0;
                     state_in  = ST_DONE;
                  end
               end
            end
         end
         ST_MARK: begin
            ram_we       = 1'b1;
            ram_waddr    = mark_addr_ff;
            ram_wdata    = 1'b1;
            mark_addr_in = mark_addr_ff + ADDR_W'(1);
            mark_left_in = mark_left_ff - CNT_W'(1);
            if (mark_left_ff == CNT_W'(1)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(CNT_W'(needed_ff)) * PROD_W'(bsize_eff);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in        = 1'b1;
               rsp_in.found        = hit_ff;
               rsp_in.parent_dir   = dir_id_ff;
               rsp_in.free_left    = FREE_W'(free_next);
               if (hit_ff) begin
                  rsp_in.start_block  = START_W'(start_ff);
                  rsp_in.entry_number = entries_ff[ENTRY_W-1:0];
                  rsp_in.blocks_taken = TAKEN_W'(needed_ff);
                  rsp_in.usable_bytes = usable;
                  entries_in          = entries_ff + ENTRY_CNT_W'(1);
                  alloc_in            = alloc_next;
               end else begin
                  rsp_in.start_block  = '0;
                  rsp_in.entry_number = '0;
                  rsp_in.blocks_taken = '0;
                  rsp_in.usable_bytes = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         entries_ff   <= '0;
         alloc_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rd_vld_ff    <= rd_vld_in;
         entries_ff   <= entries_in;
         alloc_ff     <= alloc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      needed_ff    <= needed_in;
      issue_ff     <= issue_in;
      rd_idx_ff    <= rd_idx_in;
      run_ff       <= run_in;
      start_ff     <= start_in;
      mark_addr_ff <= mark_addr_in;
      mark_left_ff <= mark_left_in;
      hit_ff       <= hit_in;
      prod_ff      <= prod_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire
